>>> hw/rtl/usbtd_pkg.sv
package usbtd_pkg;

  // Request kinds as they arrive on the input channel.
  localparam logic [2:0] ActControlSetup = 3'd0;
  localparam logic [2:0] ActControlOut   = 3'd1;
  localparam logic [2:0] ActControlIn    = 3'd2;
  localparam logic [2:0] ActBulkOut      = 3'd3;
  localparam logic [2:0] ActBulkIn       = 3'd4;
  localparam logic [2:0] ActIntrIn       = 3'd5;
  localparam logic [2:0] ActIntrOut      = 3'd6;
  // The spare code; such an item is taken and produces nothing.
  localparam logic [2:0] ActUnused       = 3'd7;

  // Schedule queues.
  localparam logic [1:0] QueueControl = 2'd0;
  localparam logic [1:0] QueueBulk    = 2'd1;
  localparam logic [1:0] QueueIntr    = 2'd2;

  // Result status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusTooLong   = 2'd1;
  localparam logic [1:0] StatusNegPeriod = 2'd2;

  // Packet identifiers.
  localparam logic [7:0] PidSetup = 8'h2D;
  localparam logic [7:0] PidOut   = 8'hE1;
  localparam logic [7:0] PidIn    = 8'h69;

  localparam int unsigned TdLimitBytes = 1024;
  localparam int unsigned MaxResults   = 64;

  // Depth of the queue between classifier and sequencer.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic [1:0]  queue;
    logic [7:0]  pid;
    logic [3:0]  endpoint;
    logic [6:0]  dev_addr;
    logic        toggle;
    logic        retry_en;
    logic [6:0]  slot;
    logic [15:0] length;
    logic [11:0] offset;
    logic [1:0]  status;
    logic        single;
  } cmd_t;

  // Head index of the interrupt tree for a given log2 step.
  function automatic logic [6:0] slot_base(input logic [2:0] idx);
    logic [6:0] s;
    case (idx)
      3'd0:    s = 7'd0;
      3'd1:    s = 7'd64;
      3'd2:    s = 7'd96;
      3'd3:    s = 7'd112;
      3'd4:    s = 7'd120;
      3'd5:    s = 7'd124;
      3'd6:    s = 7'd126;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/usbtd_if.sv
interface usbtd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [11:0]        target;
  logic               data_toggle;
  logic [15:0]        transfer_length;
  logic [11:0]        buffer_offset;
  logic signed [10:0] poll_period;

  modport source (output valid, action, target, data_toggle, transfer_length,
                  buffer_offset, poll_period, input ready);
  modport sink (input valid, action, target, data_toggle, transfer_length,
                buffer_offset, poll_period, output ready);
endinterface

interface usbtd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] control_word;
  logic [31:0] token_word;
  logic [1:0]  queue_select;
  logic [6:0]  poll_slot;
  logic        needs_bounce;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, control_word, token_word, queue_select, poll_slot,
                  needs_bounce, status, last, input ready);
  modport sink (input valid, control_word, token_word, queue_select, poll_slot,
                needs_bounce, status, last, output ready);
endinterface

>>> hw/rtl/usb_transfer_descriptor_builder_unit.sv
// A request passes through the queue, is loaded into the packet sequencer, and each of
// its descriptors is then written to the output register, one descriptor a cycle while
// the sink does not hold that register. A request yields up to 64 packets.
// The two-entry request queue lets input be taken while the sequencer is busy.
// Reset: synchronous, active low; it empties the queue, idles the sequencer and
// drops the output valid. No storage needs a clearing pass.
module usb_transfer_descriptor_builder_unit #(
  parameter int PAGE_BYTES       = 4096,
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  usbtd_in_if.sink    in_ch,
  usbtd_out_if.source out_ch
);

  // The front classifies each item as it arrives: it picks the packet
  // identifier and queue, works out the interrupt poll slot from the period,
  // and decides whether the request is rejected. Unknown actions are taken
  // and dropped without any result.
  usbtd_pkg::cmd_t push_cmd, pop_cmd;
  logic            push, pop, full, empty;

  usbtd_front #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  // A short queue separates the two halves so that each can stall on its own.
  usbtd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  // The back cuts a request into packets, flips the toggle on each one,
  // keeps the running position within the page for the bounce check, and
  // writes each descriptor into an output register, so a result waiting on
  // the sink does not stop the queue from filling.
  usbtd_back #(
    .PAGE_BYTES       (PAGE_BYTES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_cmd   (pop_cmd),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> hw/rtl/usbtd_front.sv
module usbtd_front #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  usbtd_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              q_push,
  output usbtd_pkg::cmd_t   q_cmd
);

  localparam int unsigned BulkLimit = usbtd_pkg::MaxResults * MAX_PACKET_BYTES;

  logic       known;
  logic [9:0] pp;
  logic [8:0] p9;
  logic [3:0] lg;
  logic [2:0] idx;
  logic       too_long;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && known;

  always_comb begin
    known        = 1'b1;
    q_cmd        = '0;
    q_cmd.pid    = usbtd_pkg::PidIn;
    q_cmd.queue  = usbtd_pkg::QueueControl;
    unique case (in_ch.action)
      usbtd_pkg::ActControlSetup: begin
        q_cmd.pid = usbtd_pkg::PidSetup;
      end
      usbtd_pkg::ActControlOut: begin
        q_cmd.pid = usbtd_pkg::PidOut;
      end
      usbtd_pkg::ActControlIn: begin
        q_cmd.pid = usbtd_pkg::PidIn;
      end
      usbtd_pkg::ActBulkOut: begin
        q_cmd.pid   = usbtd_pkg::PidOut;
        q_cmd.queue = usbtd_pkg::QueueBulk;
      end
      usbtd_pkg::ActBulkIn: begin
        q_cmd.pid   = usbtd_pkg::PidIn;
        q_cmd.queue = usbtd_pkg::QueueBulk;
      end
      usbtd_pkg::ActIntrIn: begin
        q_cmd.pid   = usbtd_pkg::PidIn;
        q_cmd.queue = usbtd_pkg::QueueIntr;
      end
      usbtd_pkg::ActIntrOut: begin
        q_cmd.pid   = usbtd_pkg::PidOut;
        q_cmd.queue = usbtd_pkg::QueueIntr;
      end
      default: begin
        known = 1'b0;
      end
    endcase

    // Period is clamped to 256 and turned into a floor log2.
    pp = in_ch.poll_period[9:0];
    if (pp[9] || (pp[8] && (pp[7:0] != 8'd0))) begin
      p9 = 9'd256;
    end else begin
      p9 = pp[8:0];
    end
    lg = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (p9[i]) begin
        lg = 4'(i);
      end
    end
    idx = (lg < 4'd2) ? 3'd0 : 3'(lg - 4'd2);

    if (q_cmd.queue == usbtd_pkg::QueueBulk) begin
      too_long = {16'd0, in_ch.transfer_length} > BulkLimit;
    end else begin
      too_long = in_ch.transfer_length > 16'(usbtd_pkg::TdLimitBytes);
    end

    q_cmd.endpoint = in_ch.target[3:0];
    q_cmd.dev_addr = in_ch.target[10:4];
    q_cmd.length   = in_ch.transfer_length;
    q_cmd.offset   = in_ch.buffer_offset;
    q_cmd.single   = q_cmd.queue != usbtd_pkg::QueueBulk;

    if (q_cmd.queue == usbtd_pkg::QueueIntr) begin
      q_cmd.toggle   = 1'b0;
      q_cmd.retry_en = 1'b0;
      q_cmd.slot     = usbtd_pkg::slot_base(idx);
    end else begin
      q_cmd.toggle   = in_ch.data_toggle;
      q_cmd.retry_en = 1'b1;
      q_cmd.slot     = 7'd0;
    end

    // A negative period is checked ahead of the length.
    if (q_cmd.queue == usbtd_pkg::QueueIntr && in_ch.poll_period[10]) begin
      q_cmd.status = usbtd_pkg::StatusNegPeriod;
    end else if (too_long) begin
      q_cmd.status = usbtd_pkg::StatusTooLong;
    end else begin
      q_cmd.status = usbtd_pkg::StatusOk;
    end
  end

endmodule

>>> hw/rtl/usbtd_queue.sv
module usbtd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  usbtd_pkg::cmd_t push_cmd,
  input  logic            pop,
  output usbtd_pkg::cmd_t pop_cmd,
  output logic            full,
  output logic            empty
);

  usbtd_pkg::cmd_t                   mem_r [usbtd_pkg::QDepth];
  logic [usbtd_pkg::QPtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [usbtd_pkg::QPtrW:0]         count_r;

  assign full    = count_r == (usbtd_pkg::QPtrW + 1)'(usbtd_pkg::QDepth);
  assign empty   = count_r == '0;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/usbtd_back.sv
module usbtd_back #(
  parameter int PAGE_BYTES       = 4096,
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  usbtd_pkg::cmd_t   q_cmd,
  output logic              q_pop,
  usbtd_out_if.source       out_ch
);

  localparam int SW = $clog2(PAGE_BYTES) + 1;
  localparam int RW = (SW > 12) ? SW : 12;

  usbtd_pkg::cmd_t cur_r;
  logic            busy_r;
  logic [15:0]     rem_r;
  logic [SW-1:0]   start_r;
  logic            toggle_r;

  logic            out_valid_r;
  logic [31:0]     ctrl_r, tok_r;
  logic [1:0]      queue_r, status_r;
  logic [6:0]      slot_r;
  logic            bounce_r, last_r;

  logic [RW-1:0]   off_m;
  logic [SW-1:0]   start_load;
  logic            fire;
  logic            is_ok, is_last;
  logic [10:0]     len, lm1;
  logic [SW-1:0]   sum, start_nxt;
  logic [31:0]     ctrl_nxt, tok_nxt;

  assign q_pop = !busy_r && !q_empty;
  assign fire  = busy_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    // Start offset folded into the page; at most four pages fit in 12 bits.
    off_m = RW'(q_cmd.offset);
    for (int i = 0; i < 4; i++) begin
      if (off_m >= RW'(PAGE_BYTES)) begin
        off_m = off_m - RW'(PAGE_BYTES);
      end
    end
    start_load = SW'(off_m);

    is_ok   = cur_r.status == usbtd_pkg::StatusOk;
    is_last = cur_r.single || !is_ok || (rem_r <= 16'(MAX_PACKET_BYTES));
    len     = is_last ? rem_r[10:0] : 11'(MAX_PACKET_BYTES);
    lm1     = len - 11'd1;
    sum     = start_r + SW'(len);
    start_nxt = (sum >= SW'(PAGE_BYTES)) ? sum - SW'(PAGE_BYTES) : sum;

    ctrl_nxt = {3'b000, {2{cur_r.retry_en}}, 2'b00, 1'b1, 1'b1, 12'd0, lm1};
    tok_nxt  = {lm1, 1'b0, toggle_r, cur_r.endpoint, cur_r.dev_addr, cur_r.pid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (fire && is_last) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r    <= q_cmd;
      rem_r    <= q_cmd.length;
      start_r  <= start_load;
      toggle_r <= q_cmd.toggle;
    end else if (fire) begin
      rem_r    <= rem_r - 16'(len);
      start_r  <= start_nxt;
      toggle_r <= !toggle_r;
    end
    if (fire) begin
      ctrl_r   <= is_ok ? ctrl_nxt : 32'd0;
      tok_r    <= is_ok ? tok_nxt : 32'd0;
      queue_r  <= cur_r.queue;
      slot_r   <= is_ok ? cur_r.slot : 7'd0;
      bounce_r <= is_ok && (sum > SW'(PAGE_BYTES));
      status_r <= cur_r.status;
      last_r   <= is_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.control_word = ctrl_r;
  assign out_ch.token_word   = tok_r;
  assign out_ch.queue_select = queue_r;
  assign out_ch.poll_slot    = slot_r;
  assign out_ch.needs_bounce = bounce_r;
  assign out_ch.status       = status_r;
  assign out_ch.last         = last_r;

`ifndef SYNTHESIS
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != usbtd_pkg::StatusOk) |-> last_r && (ctrl_r == 32'd0))
    else $error("rejected request result is not a lone final item");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_last |=> !busy_r)
    else $error("sequencer still busy after final descriptor");

  a_slot_intr_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (queue_r != usbtd_pkg::QueueIntr) |-> slot_r == 7'd0)
    else $error("poll slot set outside the interrupt queue");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> busy_r && !q_pop)
    else $error("request taken while another is in progress");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// Testbench for the transfer descriptor builder. Requests are driven onto the
// input channel one item at a time. Each accepted request is run through a
// model of the descriptor encoding kept in this file. The model queues the
// descriptors that the block should emit. A checker compares every descriptor
// taken from the result channel, field by field, with the oldest one still
// waiting. A short directed part covers the corner cases. Random traffic
// follows under four idling regimes on the two channels.
module tb;

  localparam int PAGE_BYTES       = 4096;
  localparam int MAX_PACKET_BYTES = 1024;
  localparam int HALF_PERIOD_NS   = 2;
  localparam int RESET_CYCLES     = 9;
  // This cut-off lies far beyond the slowest legal run and is reached only
  // if the block hangs.
  localparam int TIMEOUT_NS       = 4_000_000;
  // Idle cycles after the final descriptor, comfortably over the latency.
  localparam int DRAIN_CYCLES     = 16;

  // One transfer request, laid out as on the input channel.
  typedef struct {
    logic [2:0]         action;
    logic [11:0]        target;
    logic               data_toggle;
    logic [15:0]        transfer_length;
    logic [11:0]        buffer_offset;
    logic signed [10:0] poll_period;
  } req_t;

  // One descriptor, laid out as on the result channel.
  typedef struct {
    logic [31:0] control_word;
    logic [31:0] token_word;
    logic [1:0]  queue_select;
    logic [6:0]  poll_slot;
    logic        needs_bounce;
    logic [1:0]  status;
    logic        last;
  } desc_t;

  logic clk;
  logic rst_n;

  usbtd_in_if  in_ch ();
  usbtd_out_if out_ch ();

  usb_transfer_descriptor_builder_unit #(
    .PAGE_BYTES       (PAGE_BYTES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Descriptors that the block still owes, oldest first.
  desc_t pending_descs[$];

  int errors         = 0;
  int reqs_accepted  = 0;
  int descs_checked  = 0;
  int rejects_seen   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
  end

  always #HALF_PERIOD_NS clk = ~clk;

  // Adds a rejected request to the expected descriptors: a single descriptor
  // with the words cleared and only the queue, the status and last set.
  function automatic void push_rejection(input logic [1:0] queue, input logic [1:0] code);
    desc_t d;
    d.control_word = '0;
    d.token_word   = '0;
    d.queue_select = queue;
    d.poll_slot    = '0;
    d.needs_bounce = 1'b0;
    d.status       = code;
    d.last         = 1'b1;
    pending_descs.push_back(d);
  endfunction

  // Works out every descriptor that one request must produce and queues them
  // in the order in which the block is to emit them.
  function automatic void predict_descriptors(input req_t r);
    logic [7:0]  pid;
    logic [1:0]  queue;
    logic [6:0]  slot;
    logic [1:0]  retries;
    logic        tgl;
    logic [10:0] lm1;
    int unsigned pkt;
    int unsigned npk;
    int unsigned rem;
    int unsigned start;
    int unsigned len;
    int unsigned p;
    int unsigned lg;
    desc_t       d;

    case (r.action)
      usbtd_pkg::ActControlSetup: begin
        pid = usbtd_pkg::PidSetup; queue = usbtd_pkg::QueueControl;
      end
      usbtd_pkg::ActControlOut: begin
        pid = usbtd_pkg::PidOut; queue = usbtd_pkg::QueueControl;
      end
      usbtd_pkg::ActControlIn: begin
        pid = usbtd_pkg::PidIn; queue = usbtd_pkg::QueueControl;
      end
      usbtd_pkg::ActBulkOut: begin
        pid = usbtd_pkg::PidOut; queue = usbtd_pkg::QueueBulk;
      end
      usbtd_pkg::ActBulkIn: begin
        pid = usbtd_pkg::PidIn; queue = usbtd_pkg::QueueBulk;
      end
      usbtd_pkg::ActIntrIn: begin
        pid = usbtd_pkg::PidIn; queue = usbtd_pkg::QueueIntr;
      end
      usbtd_pkg::ActIntrOut: begin
        pid = usbtd_pkg::PidOut; queue = usbtd_pkg::QueueIntr;
      end
      default: begin
        // The unused action code is swallowed without any descriptor.
        return;
      end
    endcase

    slot    = '0;
    retries = 2'd3;
    tgl     = r.data_toggle;
    pkt     = MAX_PACKET_BYTES;

    if (queue == usbtd_pkg::QueueIntr) begin
      // A negative period is refused before the length is looked at.
      if (r.poll_period < 0) begin
        push_rejection(queue, usbtd_pkg::StatusNegPeriod);
        return;
      end
      p = (r.poll_period > 256) ? 256 : int'(r.poll_period);
      lg = 0;
      while (p > 1) begin
        p = p >> 1;
        lg++;
      end
      lg = (lg < 2) ? 0 : lg - 2;
      if (lg > 6) lg = 6;
      // Heads of the interrupt tree: 0, 64, 96, 112, 120, 124, 126.
      slot    = 7'(128 - (128 >> lg));
      retries = 2'd0;
      tgl     = 1'b0;
    end

    if (queue == usbtd_pkg::QueueBulk) begin
      npk = (r.transfer_length > pkt) ? (r.transfer_length - 1) / pkt + 1 : 1;
      if (npk > usbtd_pkg::MaxResults || pkt > usbtd_pkg::TdLimitBytes) begin
        push_rejection(queue, usbtd_pkg::StatusTooLong);
        return;
      end
    end else begin
      if (r.transfer_length > usbtd_pkg::TdLimitBytes) begin
        push_rejection(queue, usbtd_pkg::StatusTooLong);
        return;
      end
      npk = 1;
      pkt = r.transfer_length;
    end

    rem   = r.transfer_length;
    start = r.buffer_offset;
    for (int unsigned k = 0; k < npk; k++) begin
      len = (k + 1 < npk) ? pkt : rem;
      // A zero-byte packet wraps round to all ones in the length field.
      lm1 = 11'(len - 1);
      d.control_word = {3'b000, retries, 2'b00, 1'b1, 1'b1, 12'h000, lm1};
      d.token_word   = {lm1, 1'b0, tgl, r.target[3:0], r.target[10:4], pid};
      d.queue_select = queue;
      d.poll_slot    = slot;
      d.needs_bounce = ((start % PAGE_BYTES) + len > PAGE_BYTES);
      d.status       = usbtd_pkg::StatusOk;
      d.last         = (k + 1 == npk);
      pending_descs.push_back(d);
      rem   -= len;
      start += len;
      tgl    = ~tgl;
    end
  endfunction

  function automatic req_t make_req(input logic [2:0] action, input int target,
                                    input bit toggle, input int length,
                                    input int offset, input int period);
    req_t r;
    r.action          = action;
    r.target          = 12'(target);
    r.data_toggle     = toggle;
    r.transfer_length = 16'(length);
    r.buffer_offset   = 12'(offset);
    r.poll_period     = 11'(period);
    return r;
  endfunction

  // Drives one request and returns at the clock edge at which it is taken.
  // Valid is only lowered when a gap is inserted, so back-to-back items never
  // see valid dropped and raised within the same time step.
  task automatic issue_request(input req_t r);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= r.action;
    in_ch.target          <= r.target;
    in_ch.data_toggle     <= r.data_toggle;
    in_ch.transfer_length <= r.transfer_length;
    in_ch.buffer_offset   <= r.buffer_offset;
    in_ch.poll_period     <= r.poll_period;
    do @(posedge clk); while (!in_ch.ready);
    predict_descriptors(r);
    reqs_accepted++;
  endtask

  // Control transfers: every packet identifier, the length extremes and the
  // refusal of anything longer than one packet.
  task automatic test_control_requests();
    issue_request(make_req(usbtd_pkg::ActControlSetup, 0, 1'b0, 8, 0, 0));
    // A zero-length packet, and the top address bit that must be dropped.
    issue_request(make_req(usbtd_pkg::ActControlOut, 4095, 1'b1, 0, 4095, 1023));
    // A full-size packet starting on the last byte of a page needs a bounce.
    issue_request(make_req(usbtd_pkg::ActControlIn, 12'h5A3, 1'b0, 1024, 4095, -1));
    issue_request(make_req(usbtd_pkg::ActControlIn, 12'h0F0, 1'b1, 1, 3072, 0));
    issue_request(make_req(usbtd_pkg::ActControlOut, 12'h801, 1'b0, 1025, 0, 0));
    issue_request(make_req(usbtd_pkg::ActControlSetup, 12'h7FF, 1'b1, 65535, 2048, 0));
  endtask

  // Bulk transfers: splitting into full packets, the toggle alternating and
  // page crossings part way through a transfer.
  task automatic test_bulk_splitting();
    issue_request(make_req(usbtd_pkg::ActBulkOut, 12'h123, 1'b0, 0, 4095, 0));
    issue_request(make_req(usbtd_pkg::ActBulkIn, 12'h456, 1'b1, 1024, 3072, 0));
    issue_request(make_req(usbtd_pkg::ActBulkOut, 12'hABC, 1'b1, 1025, 3073, 0));
    issue_request(make_req(usbtd_pkg::ActBulkOut, 12'h321, 1'b0, 3000, 3000, 0));
    // The longest transfer there is: 64 packets, off the last byte of a page.
    issue_request(make_req(usbtd_pkg::ActBulkIn, 4095, 1'b1, 65535, 4095, -1024));
  endtask

  // Interrupt transfers: poll slots from the period, a negative period taking
  // precedence over the length, and the toggle and retries forced to zero.
  task automatic test_interrupt_requests();
    issue_request(make_req(usbtd_pkg::ActIntrIn, 12'h011, 1'b0, 4, 0, -1));
    issue_request(make_req(usbtd_pkg::ActIntrOut, 12'h022, 1'b1, 2000, 0, -1024));
    issue_request(make_req(usbtd_pkg::ActIntrIn, 12'h033, 1'b1, 8, 100, 0));
    issue_request(make_req(usbtd_pkg::ActIntrOut, 12'h044, 1'b0, 0, 4095, 7));
    issue_request(make_req(usbtd_pkg::ActIntrIn, 12'h055, 1'b1, 64, 4090, 8));
    issue_request(make_req(usbtd_pkg::ActIntrOut, 12'h066, 1'b0, 16, 0, 255));
    issue_request(make_req(usbtd_pkg::ActIntrIn, 12'h077, 1'b1, 32, 0, 256));
    issue_request(make_req(usbtd_pkg::ActIntrOut, 12'h088, 1'b0, 1024, 3072, 257));
    issue_request(make_req(usbtd_pkg::ActIntrIn, 12'h099, 1'b1, 1024, 3073, 1023));
    issue_request(make_req(usbtd_pkg::ActIntrOut, 12'hFFF, 1'b1, 1025, 0, 16));
  endtask

  // The spare action code must be taken and produce nothing.
  task automatic test_ignored_action();
    issue_request(make_req(usbtd_pkg::ActUnused, 12'hFFF, 1'b1, 65535, 4095, -1));
    issue_request(make_req(usbtd_pkg::ActUnused, 0, 1'b0, 0, 0, 0));
  endtask

  function automatic int rand_length(input int pct_full, input int common_max);
    if ($urandom_range(0, 99) < pct_full)
      return $urandom_range(0, 65535);
    return $urandom_range(0, common_max);
  endfunction

  // Mostly well-formed requests with random content, plus a few refused and
  // ignored ones. Big bulk transfers are kept rare so that the run stays short.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.target      = 12'($urandom_range(0, 4095));
    r.data_toggle = 1'($urandom_range(0, 1));
    r.buffer_offset = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(3000, 4095))
                                                  : 12'($urandom_range(0, 4095));
    r.poll_period = 11'($urandom_range(0, 2047));
    if (pick < 40) begin
      r.action = ($urandom_range(0, 1) == 0) ? usbtd_pkg::ActBulkOut : usbtd_pkg::ActBulkIn;
      if ($urandom_range(0, 9) < 2)
        r.transfer_length = 16'(rand_length(30, 8192));
      else
        r.transfer_length = 16'($urandom_range(0, 2100));
    end else if (pick < 70) begin
      r.action = 3'($urandom_range(usbtd_pkg::ActControlSetup, usbtd_pkg::ActControlIn));
      r.transfer_length = 16'(rand_length(15, 1024));
    end else if (pick < 95) begin
      r.action = ($urandom_range(0, 1) == 0) ? usbtd_pkg::ActIntrIn : usbtd_pkg::ActIntrOut;
      r.transfer_length = 16'(rand_length(15, 1024));
      // Short periods are where the slot steps lie, so weight them.
      if ($urandom_range(0, 99) < 85)
        r.poll_period = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 300))
                                                    : 11'($urandom_range(0, 1023));
      else
        r.poll_period = 11'(-int'($urandom_range(1, 1024)));
    end else begin
      r.action = usbtd_pkg::ActUnused;
      r.transfer_length = 16'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    req_t r;
    int   sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      r = random_request();
      issue_request(r);
      // Ignored items are noise and do not count towards the phase.
      if (r.action != usbtd_pkg::ActUnused) sent++;
    end
  endtask

  // The receiver stalls on its own schedule, regardless of the traffic.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every descriptor taken from the block is matched against the oldest one
  // the model still holds.
  always @(posedge clk) begin
    desc_t d;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_descs.size() == 0) begin
        $display("%0t ns: descriptor with none expected, expected nothing, got ctrl 0x%0h tok 0x%0h",
                 $time, out_ch.control_word, out_ch.token_word);
        errors++;
      end else begin
        d = pending_descs.pop_front();
        report_field("control_word", d.control_word, out_ch.control_word);
        report_field("token_word", d.token_word, out_ch.token_word);
        report_field("queue_select", 32'(d.queue_select), 32'(out_ch.queue_select));
        report_field("poll_slot", 32'(d.poll_slot), 32'(out_ch.poll_slot));
        report_field("needs_bounce", 32'(d.needs_bounce), 32'(out_ch.needs_bounce));
        report_field("status", 32'(d.status), 32'(out_ch.status));
        report_field("last", 32'(d.last), 32'(out_ch.last));
        if (d.status != usbtd_pkg::StatusOk) rejects_seen++;
        descs_checked++;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d descriptors outstanding", pending_descs.size());
    $display("usb_transfer_descriptor_builder_unit: mismatch");
    $finish;
  end

  initial begin
    // Every input of the block is at a known level from time zero.
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.action          = '0;
    in_ch.target          = '0;
    in_ch.data_toggle     = 1'b0;
    in_ch.transfer_length = '0;
    in_ch.buffer_offset   = '0;
    in_ch.poll_period     = '0;
    out_ch.ready          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_control_requests();
    test_bulk_splitting();
    test_interrupt_requests();
    test_ignored_action();

    // Four regimes: free flowing, a sparse sender, a sluggish receiver, and
    // light idling on both sides.
    test_random_traffic(55, 0, 0);
    test_random_traffic(55, 85, 0);
    test_random_traffic(55, 0, 85);
    test_random_traffic(55, 15, 15);

    in_ch.valid <= 1'b0;
    while (pending_descs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_descs.size() != 0) errors++;

    $display("Covered %0d requests of every kind under four idling regimes;", reqs_accepted);
    $display("checked %0d descriptors, %0d of them rejections, %0d errors.",
             descs_checked, rejects_seen, errors);
    if (errors == 0) begin
      $display("usb_transfer_descriptor_builder_unit: match");
    end else begin
      $display("usb_transfer_descriptor_builder_unit: mismatch");
    end
    $finish;
  end

endmodule
